// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

`endif

// ----- hw/rtl/sqmm_pkg.sv -----
`default_nettype none

package sqmm_pkg;

	// Build default for the largest matrix dimension
	localparam int MAX_DIM_DEFAULT = 16;

	// Fixed field widths
	localparam int SIZE_W = 5;
	localparam int ROW_W  = 4;
	localparam int VAL_W  = 64;
	localparam int REQ_W  = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_WRITE_A = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE_B = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic start;     // latch row/col, clear accumulator
		logic in_range;  // read lies inside the active matrix
		logic issue;     // read one A/B pair this cycle
		logic wr_a;      // store element into A
		logic wr_b;      // store element into B
		logic load_out;  // move accumulator into output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic pipe_busy; // multiply-accumulate pipe still holds pairs
	} dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sqmm_datapath.sv -----
`default_nettype none

module sqmm_datapath
	import sqmm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEFAULT,
	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dp_cmd_t          cmd,
	input  wire logic [DIM_W-1:0] k_idx,
	input  wire logic [ROW_W-1:0] row_index,
	input  wire logic [ROW_W-1:0] col_index,
	input  wire logic [VAL_W-1:0] element_value,
	output dp_status_t            status,
	output logic      [ROW_W-1:0] result_row,
	output logic      [ROW_W-1:0] result_col,
	output logic      [VAL_W-1:0] product_value
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW    = AW + ROW_W + 1;

	logic [VAL_W-1:0] mem_a [DEPTH];
	logic [VAL_W-1:0] mem_b [DEPTH];

	logic [ROW_W-1:0] row_q;
	logic [ROW_W-1:0] col_q;
	logic             in_range_q;

	logic [MW-1:0]    wr_full;
	logic [MW-1:0]    ra_full;
	logic [MW-1:0]    rb_full;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    ra_addr;
	logic [AW-1:0]    rb_addr;
	logic             wr_ok;

	logic [VAL_W-1:0] a_rd_s1;
	logic [VAL_W-1:0] b_rd_s1;
	logic             vld_s1;
	logic [63:0]      p_ll_s2;
	logic [31:0]      p_lh_s2;
	logic [31:0]      p_hl_s2;
	logic             vld_s2;
	logic [VAL_W-1:0] term;
	logic [VAL_W-1:0] acc_q;

	logic [ROW_W-1:0] result_row_q;
	logic [ROW_W-1:0] result_col_q;
	logic [VAL_W-1:0] product_value_q;

	// Store addresses, row-major
	assign wr_ok   = (MW'(row_index) < MW'(MAX_DIM)) && (MW'(col_index) < MW'(MAX_DIM));
	assign wr_full = MW'(row_index) * MW'(MAX_DIM) + MW'(col_index);
	assign ra_full = MW'(row_q) * MW'(MAX_DIM) + MW'(k_idx);
	assign rb_full = MW'(k_idx) * MW'(MAX_DIM) + MW'(col_q);
	assign wr_addr = wr_full[AW-1:0];
	assign ra_addr = ra_full[AW-1:0];
	assign rb_addr = rb_full[AW-1:0];

	// Request context for the read in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
		end else if (cmd.start) begin
			in_range_q <= cmd.in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q <= row_index;
			col_q <= col_index;
		end
	end

	// Matrix A store
	always_ff @(posedge clk) begin
		if (cmd.wr_a && wr_ok) begin
			mem_a[wr_addr] <= element_value;
		end
		if (cmd.issue) begin
			a_rd_s1 <= mem_a[ra_addr];
		end
	end

	// Matrix B store
	always_ff @(posedge clk) begin
		if (cmd.wr_b && wr_ok) begin
			mem_b[wr_addr] <= element_value;
		end
		if (cmd.issue) begin
			b_rd_s1 <= mem_b[rb_addr];
		end
	end

	// Pipe valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	// Partial products; cross terms only matter mod 2^32 after the shift
	always_ff @(posedge clk) begin
		p_ll_s2 <= 64'(a_rd_s1[31:0]) * 64'(b_rd_s1[31:0]);
		p_lh_s2 <= a_rd_s1[31:0] * b_rd_s1[63:32];
		p_hl_s2 <= a_rd_s1[63:32] * b_rd_s1[31:0];
	end

	assign term = p_ll_s2 + {p_lh_s2 + p_hl_s2, 32'b0};

	// Accumulator, wraps mod 2^64
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (vld_s2 && in_range_q) begin
			acc_q <= acc_q + term;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_row_q    <= row_q;
			result_col_q    <= col_q;
			product_value_q <= acc_q;
		end
	end

	assign status.pipe_busy = vld_s1 | vld_s2;
	assign result_row       = result_row_q;
	assign result_col       = result_col_q;
	assign product_value    = product_value_q;

endmodule

`default_nettype wire

// ----- hw/rtl/sqmm_ctrl.sv -----
`default_nettype none

module sqmm_ctrl
	import sqmm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEFAULT,
	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [ROW_W-1:0]  row_index,
	input  wire logic [ROW_W-1:0]  col_index,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_wdata,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire dp_status_t        status,
	output dp_cmd_t                cmd,
	output logic      [DIM_W-1:0]  k_idx
);

	localparam int CNT_W = $clog2(MAX_DIM + 1);
	localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	logic [SIZE_W-1:0] size_q;
	logic [DIM_W-1:0]  k_q;
	logic [DIM_W-1:0]  k_d;
	logic              out_valid_q;
	logic [CNT_W-1:0]  dim_n;
	logic              in_range;
	logic              last_k;
	logic              slot_free;

	// Active dimension: zero acts as one, clamp at the built maximum
	always_comb begin
		if (size_q == '0) begin
			dim_n = CNT_W'(1);
		end else if (SZ_W'(size_q) > SZ_W'(MAX_DIM)) begin
			dim_n = CNT_W'(MAX_DIM);
		end else begin
			dim_n = CNT_W'(size_q);
		end
	end

	assign in_range  = (SZ_W'(row_index) < SZ_W'(dim_n)) && (SZ_W'(col_index) < SZ_W'(dim_n));
	assign last_k    = (SZ_W'(k_q) == SZ_W'(dim_n) - SZ_W'(1));
	assign slot_free = !out_valid_q || !out_stall;

	// Size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// State, index counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (req_type)
						REQ_WRITE_A: cmd.wr_a = 1'b1;
						REQ_WRITE_B: cmd.wr_b = 1'b1;
						REQ_READ: begin
							cmd.start    = 1'b1;
							cmd.in_range = in_range;
							k_d          = '0;
							state_d      = ST_RUN;
						end
						default: ;
					endcase
				end
			end
			ST_RUN: begin
				cmd.issue = 1'b1;
				if (last_k) begin
					state_d = ST_DRAIN;
				end else begin
					k_d = k_q + DIM_W'(1);
				end
			end
			ST_DRAIN: begin
				// wait for the last product to land and the output slot to open
				if (!status.pipe_busy && slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign k_idx     = k_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/square_matrix_multiply_u64_core.sv -----
// Square matrix multiplier, unsigned 64-bit elements, wrapping mod 2^64.
// Input channel (in_valid / in_stall) carries requests: req_type selects a
// write of element_value into A or B at row_index/col_index, or a read of
// product element (row_index, col_index). A request is taken at a clock edge
// with in_valid high and in_stall low. Writes finish in the accept cycle and
// the next request may follow at once. Reserved request codes are dropped.
// A read walks k = 0..N-1 through both element memories, one pair per cycle,
// into a three-stage multiply-accumulate pipe (read, partial products, add).
// With N the active dimension, a read keeps in_stall high until its result is
// loaded into the output register. Reads outside the active matrix return zero
// and take as long as any other read. Output channel (out_valid / out_stall)
// carries one result per read from an output register; a stalled result holds,
// and the block may take further requests while it waits. A read that finishes
// against a still-full output register waits in the drain state. The dimension,
// set by cfg_we/cfg_wdata, must be written by the user only while idle; the
// block does not enforce this. Reset returns the size to 16 and clears control;
// the element memories are not cleared and must be written before use.
`default_nettype none

module square_matrix_multiply_u64_core
	import sqmm_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [REQ_W-1:0]  req_type,
	input  wire logic [ROW_W-1:0]  row_index,
	input  wire logic [ROW_W-1:0]  col_index,
	input  wire logic [VAL_W-1:0]  element_value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [ROW_W-1:0]  result_row,
	output logic      [ROW_W-1:0]  result_col,
	output logic      [VAL_W-1:0]  product_value,
	input  wire logic              cfg_we,
	input  wire logic [SIZE_W-1:0] cfg_wdata
);

	localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	dp_cmd_t          cmd;
	dp_status_t       status;
	logic [DIM_W-1:0] k_idx;

	sqmm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.row_index (row_index),
		.col_index (col_index),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.k_idx     (k_idx)
	);

	sqmm_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.k_idx         (k_idx),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.status        (status),
		.result_row    (result_row),
		.result_col    (result_col),
		.product_value (product_value)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/sqmm_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module sqmm_checker
	import sqmm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic [REQ_W-1:0] req_type,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [ROW_W-1:0] result_row,
	input wire logic [ROW_W-1:0] result_col,
	input wire logic [VAL_W-1:0] product_value
);

	logic                       in_fire;
	logic                       is_read;
	logic [2*ROW_W+VAL_W-1:0]   out_bus;

	assign in_fire = in_valid && !in_stall;
	assign is_read = (req_type == REQ_READ);
	assign out_bus = {result_row, result_col, product_value};

	// A stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_bus))

	// A read request occupies the block in the following cycle
	`ASSERT_NEXT(a_read_busy, clk, arst_n, in_fire && is_read, in_stall && !$rose(out_valid))

	// Any other request leaves the input open
	`ASSERT_NEXT(a_write_open, clk, arst_n, in_fire && !is_read, !in_stall)

	// A new result only comes out of a read in progress
	`ASSERT_NOW(a_result_src, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind square_matrix_multiply_u64_core sqmm_checker u_checker (.*);

`default_nettype wire

// ----- tb/tb_square_matrix_multiply_u64_core.sv -----
`default_nettype none

import sqmm_pkg::*;

typedef struct {
	bit [ROW_W-1:0] row;
	bit [ROW_W-1:0] col;
	bit [VAL_W-1:0] value;
} product_t;

// Tracks both element stores and the dimension, predicts each product read
class product_scoreboard;
	bit [VAL_W-1:0] a_elems [MAX_DIM_DEFAULT*MAX_DIM_DEFAULT];
	bit [VAL_W-1:0] b_elems [MAX_DIM_DEFAULT*MAX_DIM_DEFAULT];
	bit [SIZE_W-1:0] dim_reg;
	product_t expected_products [$];
	int errors;

	function new();
		dim_reg = SIZE_RESET;
		errors = 0;
	endfunction

	function void set_dim(bit [SIZE_W-1:0] v);
		dim_reg = v;
	endfunction

	// zero acts as one, anything above the built maximum acts as the maximum
	function int unsigned active_dim();
		if (dim_reg == 0)
			return 1;
		if (dim_reg > MAX_DIM_DEFAULT)
			return MAX_DIM_DEFAULT;
		return 32'(dim_reg);
	endfunction

	function int unsigned outstanding();
		return expected_products.size();
	endfunction

	function void note_request(logic [REQ_W-1:0] kind, logic [ROW_W-1:0] r,
			logic [ROW_W-1:0] c, logic [VAL_W-1:0] v);
		int unsigned n;
		bit [VAL_W-1:0] acc;
		product_t p;
		n = active_dim();
		if (kind == REQ_WRITE_A) begin
			a_elems[r*MAX_DIM_DEFAULT + c] = v;
		end else if (kind == REQ_WRITE_B) begin
			b_elems[r*MAX_DIM_DEFAULT + c] = v;
		end else if (kind == REQ_READ) begin
			acc = '0;
			// outside the active matrix the sum stays zero
			if (r < n && c < n)
				for (int k = 0; k < n; k++)
					acc += a_elems[r*MAX_DIM_DEFAULT + k] * b_elems[k*MAX_DIM_DEFAULT + c];
			p.row = r;
			p.col = c;
			p.value = acc;
			expected_products.push_back(p);
		end
	endfunction

	function void check_product(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c,
			logic [VAL_W-1:0] v);
		product_t p;
		if (expected_products.size() == 0) begin
			$display("%0t: unexpected result row %0d col %0d value %h", $time, r, c, v);
			errors++;
			return;
		end
		p = expected_products.pop_front();
		if (r !== p.row) begin
			$display("%0t: result_row expected %0d got %0d", $time, p.row, r);
			errors++;
		end
		if (c !== p.col) begin
			$display("%0t: result_col expected %0d got %0d", $time, p.col, c);
			errors++;
		end
		if (v !== p.value) begin
			$display("%0t: product_value expected %h got %h", $time, p.value, v);
			errors++;
		end
	endfunction
endclass

module tb_square_matrix_multiply_u64_core;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES   = MAX_DIM_DEFAULT + 8;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 64;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [REQ_W-1:0]  req_type;
	logic [ROW_W-1:0]  row_index;
	logic [ROW_W-1:0]  col_index;
	logic [VAL_W-1:0]  element_value;
	logic              out_valid;
	logic              out_stall;
	logic [ROW_W-1:0]  result_row;
	logic [ROW_W-1:0]  result_col;
	logic [VAL_W-1:0]  product_value;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_wdata;

	product_scoreboard sb;
	bit a_loaded [MAX_DIM_DEFAULT*MAX_DIM_DEFAULT];
	bit b_loaded [MAX_DIM_DEFAULT*MAX_DIM_DEFAULT];
	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	bit hold_request;
	int unsigned idle_cycles;

	square_matrix_multiply_u64_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_row    (result_row),
		.result_col    (result_col),
		.product_value (product_value),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_request(req_type, row_index, col_index, element_value);
			if (out_valid && !out_stall)
				sb.check_product(result_row, result_col, product_value);
		end
	end

	// Result side: random stall, or one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
			end
		end
	end

	// Watchdog: cycles in a row with no request and no result taken
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("square_matrix_multiply_u64_core: mismatch");
		$finish;
	end

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2: return 64'h8000_0000_0000_0000;
			3: return 64'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random gaps first, then hold the request until it is taken
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] c, input logic [VAL_W-1:0] v);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		req_type      <= kind;
		row_index     <= r;
		col_index     <= c;
		element_value <= v;
		if (kind == REQ_WRITE_A)
			a_loaded[{r, c}] = 1'b1;
		else if (kind == REQ_WRITE_B)
			b_loaded[{r, c}] = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Mostly reads, biased to corner rows/cols so full sums get loaded early
	task automatic random_request(output logic [REQ_W-1:0] kind, output logic [ROW_W-1:0] r,
			output logic [ROW_W-1:0] c, output logic [VAL_W-1:0] v);
		int unsigned n;
		int unsigned pick;
		bit found;
		n = sb.active_dim();
		pick = $urandom_range(0, 99);
		v = pick_value();
		r = ROW_W'($urandom_range(0, 15));
		c = ROW_W'($urandom_range(0, 15));
		if (pick < 5) begin
			kind = REQ_UNUSED;
		end else if (pick < 45) begin
			kind = $urandom_range(0, 1) ? REQ_WRITE_A : REQ_WRITE_B;
			if ($urandom_range(0, 99) < 70) begin
				r = ROW_W'($urandom_range(0, n - 1));
				c = ROW_W'($urandom_range(0, n - 1));
			end
		end else begin
			kind = REQ_READ;
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 1)) begin
					r = $urandom_range(0, 1) ? ROW_W'(0) : ROW_W'(n - 1);
					c = $urandom_range(0, 1) ? ROW_W'(0) : ROW_W'(n - 1);
				end else begin
					r = ROW_W'($urandom_range(0, n - 1));
					c = ROW_W'($urandom_range(0, n - 1));
				end
			end
			// never sum an element that was not written: load the first gap instead
			found = 1'b0;
			if (r < n && c < n)
				for (int k = 0; k < n && !found; k++) begin
					if (!a_loaded[r*MAX_DIM_DEFAULT + k]) begin
						kind = REQ_WRITE_A;
						c = ROW_W'(k);
						found = 1'b1;
					end else if (!b_loaded[k*MAX_DIM_DEFAULT + c]) begin
						kind = REQ_WRITE_B;
						r = ROW_W'(k);
						found = 1'b1;
					end
				end
		end
	endtask

	// Stop sending, let every product arrive, then give the pipe time to empty
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_dimension(input logic [SIZE_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_dim(v);
	endtask

	initial begin
		logic [SIZE_W-1:0] phase_dims [6];
		logic [REQ_W-1:0] kind;
		logic [ROW_W-1:0] r;
		logic [ROW_W-1:0] c;
		logic [VAL_W-1:0] v;
		int count;

		sb = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		req_type      = REQ_WRITE_A;
		row_index     = '0;
		col_index     = '0;
		element_value = '0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		hold_request  = 1'b0;
		sender_idle_pct   = 21;
		receiver_idle_pct = 79;
		phase_dims = '{5'd1, 5'd4, 5'd16, 5'd0, 5'd31, 5'd3};

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: 2x2 matrix, wraparound sums, writes and reads outside it
		set_dimension(5'd2);
		send_request(REQ_WRITE_A, 4'd0, 4'd0, '1);
		send_request(REQ_WRITE_A, 4'd0, 4'd1, '1);
		send_request(REQ_WRITE_B, 4'd0, 4'd0, '1);
		send_request(REQ_WRITE_B, 4'd1, 4'd0, 64'd2);
		send_request(REQ_READ, 4'd0, 4'd0, '0);
		send_request(REQ_WRITE_A, 4'd1, 4'd0, '0);
		send_request(REQ_WRITE_A, 4'd1, 4'd1, 64'h8000_0000_0000_0000);
		send_request(REQ_WRITE_B, 4'd0, 4'd1, 64'h0123_4567_89ab_cdef);
		send_request(REQ_WRITE_B, 4'd1, 4'd1, 64'd2);
		send_request(REQ_READ, 4'd1, 4'd1, '1);
		send_request(REQ_READ, 4'd0, 4'd1, '0);
		send_request(REQ_READ, 4'd1, 4'd0, '0);
		send_request(REQ_WRITE_A, 4'd15, 4'd15, 64'h5555_5555_5555_5555);
		send_request(REQ_WRITE_B, 4'd15, 4'd15, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(REQ_UNUSED, 4'd15, 4'd15, '1);
		send_request(REQ_READ, 4'd2, 4'd0, '0);
		send_request(REQ_READ, 4'd15, 4'd15, '0);
		send_request(REQ_READ, 4'd0, 4'd15, '0);
		send_request(REQ_READ, 4'd15, 4'd0, '0);
		settle();

		// Random phases over several dimensions and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			set_dimension(phase_dims[ph]);
			sender_idle_pct   = (ph < 2) ? 21 : (ph < 4) ? 79 : 0;
			receiver_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 21 : 0;
			count = 0;
			while (count < PHASE_ITEMS) begin
				if (count == PHASE_ITEMS / 2) begin
					if (ph == 1)
						hold_request = 1'b1;
					else if (ph == 2)
						settle();
				end
				random_request(kind, r, c, v);
				send_request(kind, r, c, v);
				if (kind != REQ_UNUSED)
					count++;
			end
			settle();
		end

		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("square_matrix_multiply_u64_core: match");
		else
			$display("square_matrix_multiply_u64_core: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/sqmm_pkg.sv
hw/rtl/sqmm_datapath.sv
hw/rtl/sqmm_ctrl.sv
hw/rtl/square_matrix_multiply_u64_core.sv
hw/rtl/sqmm_checker.sv
tb/tb_square_matrix_multiply_u64_core.sv
